// ===== hdl/spq_pkg.sv =====
package spq_pkg;

	// operation codes carried on the command channel
	typedef enum logic [1:0] {
		ACT_PUSH     = 2'd0,
		ACT_POP      = 2'd1,
		ACT_CONTAINS = 2'd2,
		ACT_CHANGE   = 2'd3
	} action_t;

endpackage

// ===== hdl/spq_if.sv =====
// command channel: one operation per beat
interface spq_cmd_if #(
	parameter int ID_BITS       = 10,
	parameter int PRIORITY_BITS = 16
);
	logic                     valid;
	logic                     ready;
	spq_pkg::action_t         action;
	logic [ID_BITS-1:0]       item_id;
	logic [ID_BITS-1:0]       item_source;
	logic [PRIORITY_BITS-1:0] item_priority;

	modport source (output valid, action, item_id, item_source, item_priority, input ready);
	modport sink   (input valid, action, item_id, item_source, item_priority, output ready);
endinterface

// response channel: one result per command
interface spq_rsp_if #(
	parameter int ID_BITS       = 10,
	parameter int PRIORITY_BITS = 16
);
	logic                     valid;
	logic                     ready;
	logic                     popped_valid;
	logic [ID_BITS-1:0]       out_id;
	logic [ID_BITS-1:0]       out_source;
	logic [PRIORITY_BITS-1:0] out_priority;
	logic                     found;
	logic                     dropped_full;
	logic                     was_empty;

	modport source (output valid, popped_valid, out_id, out_source, out_priority, found,
		dropped_full, was_empty, input ready);
	modport sink   (input valid, popped_valid, out_id, out_source, out_priority, found,
		dropped_full, was_empty, output ready);
endinterface

// ===== hdl/spq_ram.sv =====
module spq_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== hdl/sorted_priority_queue.sv =====
// Sorted priority queue on a circular buffer in one RAM, one entry moved per cycle.
// Pop reads the head; Contains scans from the head to the match or the last entry.
// Push seeks the tail, shifts larger-priority entries back one slot, then inserts.
// Change: find, then close the gap over the later entries, then a push-style insert.
// One operation in flight; one RAM read and one RAM write per cycle set the pace.
// Reset (arst_n low) empties the queue; RAM contents need no clearing.
module sorted_priority_queue #(
	parameter int QUEUE_DEPTH   = 64,
	parameter int ID_BITS       = 10,
	parameter int PRIORITY_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	spq_cmd_if.sink        cmd,
	spq_rsp_if.source      rsp
);
	import spq_pkg::*;

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int IW = ID_BITS;
	localparam int PW = PRIORITY_BITS;
	localparam int EW = 2 * IW + PW;
	localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);
	localparam logic [CW-1:0] ONE_CNT = CW'(1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_POP   = 7'b0000010,
		ST_FIND  = 7'b0000100,
		ST_REM   = 7'b0001000,
		ST_SEEK  = 7'b0010000,
		ST_INS   = 7'b0100000,
		ST_PLACE = 7'b1000000
	} state_t;

	typedef struct packed {
		logic          popped_valid;
		logic [IW-1:0] id;
		logic [IW-1:0] source;
		logic [PW-1:0] priority_v;
		logic          found;
		logic          dropped_full;
		logic          was_empty;
	} result_t;

	state_t         state_q;
	logic           done_q;
	logic [CW-1:0]  count_q;
	logic [AW-1:0]  head_q;
	logic [CW-1:0]  idx_q;
	action_t        act_q;
	logic [EW-1:0]  ent_q;
	result_t        res_q;
	result_t        out_q;
	logic           ov_q;

	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	logic [EW-1:0]  ram_wdata;
	logic [AW-1:0]  ram_raddr;
	logic [EW-1:0]  ram_rdata;

	logic           cmd_fire;
	logic           out_free;
	logic [IW-1:0]  rd_id;
	logic [IW-1:0]  rd_src;
	logic [PW-1:0]  rd_prio;
	logic [IW-1:0]  ent_id;
	logic [PW-1:0]  ent_prio;
	logic           is_last;
	logic           rem_last;

	// logical position to physical slot, wrapping around the buffer
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] pos);
		logic [CW:0] sum;
		sum = {{(CW + 1 - AW){1'b0}}, head} + {1'b0, pos};
		if (sum >= (CW + 1)'(QUEUE_DEPTH)) begin
			sum = sum - (CW + 1)'(QUEUE_DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	spq_ram #(
		.WIDTH(EW),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_id    = ram_rdata[EW-1 -: IW];
	assign rd_src   = ram_rdata[PW+IW-1 -: IW];
	assign rd_prio  = ram_rdata[PW-1:0];
	assign ent_id   = ent_q[EW-1 -: IW];
	assign ent_prio = ent_q[PW-1:0];
	assign is_last  = (idx_q + ONE_CNT) == count_q;
	assign rem_last = (idx_q + CW'(2)) == count_q;

	assign cmd.ready = (state_q == ST_IDLE) && !done_q;
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign out_free  = !ov_q || rsp.ready;

	// RAM port control for the current step
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = phys(head_q, idx_q);
		ram_wdata = ent_q;
		ram_raddr = phys(head_q, '0);
		case (state_q)
			ST_FIND: begin
				ram_raddr = phys(head_q, idx_q + ONE_CNT);
			end
			ST_REM: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
				ram_raddr = phys(head_q, idx_q + CW'(2));
			end
			ST_SEEK: begin
				ram_raddr = phys(head_q, count_q - ONE_CNT);
			end
			ST_INS: begin
				ram_we    = 1'b1;
				ram_raddr = phys(head_q, idx_q - CW'(2));
				if (rd_prio > ent_prio) begin
					ram_wdata = ram_rdata;
				end
			end
			ST_PLACE: begin
				ram_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			count_q <= '0;
			head_q  <= '0;
			ov_q    <= 1'b0;
		end else begin
			// output register holds a beat until it is taken
			ov_q <= (done_q && out_free) || (ov_q && !rsp.ready);
			// hand a finished result to the output register
			if (done_q && out_free) begin
				done_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						case (cmd.action)
							ACT_PUSH: begin
								if (count_q == FULL_CNT) begin
									done_q <= 1'b1;
								end else begin
									state_q <= ST_SEEK;
								end
							end
							ACT_POP: begin
								if (count_q == '0) begin
									done_q <= 1'b1;
								end else begin
									state_q <= ST_POP;
								end
							end
							default: begin
								if (count_q == '0) begin
									done_q <= 1'b1;
								end else begin
									state_q <= ST_FIND;
								end
							end
						endcase
					end
				end
				ST_POP: begin
					head_q  <= (head_q == LAST_SLOT) ? '0 : head_q + AW'(1);
					count_q <= count_q - ONE_CNT;
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				ST_FIND: begin
					if (rd_id == ent_id) begin
						if (act_q == ACT_CONTAINS) begin
							state_q <= ST_IDLE;
							done_q  <= 1'b1;
						end else if (is_last) begin
							count_q <= count_q - ONE_CNT;
							state_q <= ST_SEEK;
						end else begin
							state_q <= ST_REM;
						end
					end else if (is_last) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				ST_REM: begin
					if (rem_last) begin
						count_q <= count_q - ONE_CNT;
						state_q <= ST_SEEK;
					end
				end
				ST_SEEK: begin
					state_q <= (count_q == '0) ? ST_PLACE : ST_INS;
				end
				ST_INS: begin
					if (rd_prio > ent_prio) begin
						if (idx_q == ONE_CNT) begin
							state_q <= ST_PLACE;
						end
					end else begin
						count_q <= count_q + ONE_CNT;
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				ST_PLACE: begin
					count_q <= count_q + ONE_CNT;
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working registers: operand, position and result under construction
	always_ff @(posedge clk) begin
		if (done_q && out_free) begin
			out_q <= res_q;
		end
		case (state_q)
			ST_IDLE: begin
				if (cmd_fire) begin
					act_q <= cmd.action;
					ent_q <= {cmd.item_id, cmd.item_source, cmd.item_priority};
					idx_q <= '0;
					res_q <= '{
						popped_valid: 1'b0,
						id:           '0,
						source:       '0,
						priority_v:   '0,
						found:        1'b0,
						dropped_full: (cmd.action == ACT_PUSH) && (count_q == FULL_CNT),
						was_empty:    (cmd.action == ACT_POP) && (count_q == '0)
					};
				end
			end
			ST_POP: begin
				res_q.popped_valid <= 1'b1;
				res_q.id           <= rd_id;
				res_q.source       <= rd_src;
				res_q.priority_v   <= rd_prio;
			end
			ST_FIND: begin
				if (rd_id == ent_id) begin
					res_q.found           <= 1'b1;
					ent_q[PW+IW-1 -: IW] <= rd_src;
				end else begin
					idx_q <= idx_q + ONE_CNT;
				end
			end
			ST_REM: begin
				idx_q <= idx_q + ONE_CNT;
			end
			ST_SEEK: begin
				idx_q <= count_q;
			end
			ST_INS: begin
				if (rd_prio > ent_prio) begin
					idx_q <= idx_q - ONE_CNT;
				end
			end
			default: begin
			end
		endcase
	end

	// response beat
	assign rsp.valid        = ov_q;
	assign rsp.popped_valid = out_q.popped_valid;
	assign rsp.out_id       = out_q.id;
	assign rsp.out_source   = out_q.source;
	assign rsp.out_priority = out_q.priority_v;
	assign rsp.found        = out_q.found;
	assign rsp.dropped_full = out_q.dropped_full;
	assign rsp.was_empty    = out_q.was_empty;

	// occupancy never passes the buffer size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count above queue depth");

	// RAM is written only by the shifting and placing steps
	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_REM || state_q == ST_INS || state_q == ST_PLACE))
		else $error("RAM write outside a move step");

	// occupancy only moves on pop, removal or placement
	a_count_move: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> ($past(state_q) == ST_POP || $past(state_q) == ST_FIND
			|| $past(state_q) == ST_REM || $past(state_q) == ST_INS
			|| $past(state_q) == ST_PLACE))
		else $error("entry count changed outside an update step");

	// a result with a popped entry carries no other status
	a_pop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.popped_valid) |-> !(rsp.was_empty || rsp.found || rsp.dropped_full))
		else $error("popped result carries other status");

endmodule
